@@ rtl/dct_pkg.sv @@
// ----------------------------------------------------------------------------
// dct_pkg
// shared types, character codes, token kinds and error codes of the tokenizer
// ----------------------------------------------------------------------------
package dct_pkg;

    localparam int POSITION_WIDTH_DEF = 16;
    localparam int LENGTH_WIDTH_DEF   = 16;
    localparam int KIND_W             = 5;
    localparam int ERR_W              = 3;

    // byte with its class flags
    typedef struct packed {
        logic [7:0] code;
        logic       digit;
        logic       alpha;
    } char_t;

    // head of the input queue
    typedef struct packed {
        logic  valid;
        char_t ch;
    } head_t;

    // writes into the output queue
    typedef struct packed {
        logic a_v;
        logic b_v;
    } push_t;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_NUMBER  = 2'd1;
    localparam logic [1:0] MODE_IDENT   = 2'd2;
    localparam logic [1:0] MODE_COMMENT = 2'd3;

    localparam logic [4:0] KIND_EOF        = 5'd0;
    localparam logic [4:0] KIND_ERROR      = 5'd1;
    localparam logic [4:0] KIND_LPAREN     = 5'd2;
    localparam logic [4:0] KIND_RPAREN     = 5'd3;
    localparam logic [4:0] KIND_LBRACE     = 5'd4;
    localparam logic [4:0] KIND_RBRACE     = 5'd5;
    localparam logic [4:0] KIND_INTEGER    = 5'd6;
    localparam logic [4:0] KIND_FLOAT      = 5'd7;
    localparam logic [4:0] KIND_DOT        = 5'd8;
    localparam logic [4:0] KIND_IDENTIFIER = 5'd9;
    localparam logic [4:0] KIND_EQUALITY   = 5'd10;
    localparam logic [4:0] KIND_ASSIGN     = 5'd11;
    localparam logic [4:0] KIND_NOTEQUAL   = 5'd12;
    localparam logic [4:0] KIND_NOT        = 5'd13;
    localparam logic [4:0] KIND_PLUS       = 5'd14;
    localparam logic [4:0] KIND_RETURNS    = 5'd15;
    localparam logic [4:0] KIND_MINUS      = 5'd16;
    localparam logic [4:0] KIND_DIVIDE     = 5'd17;
    localparam logic [4:0] KIND_TIMES      = 5'd18;
    localparam logic [4:0] KIND_POWER      = 5'd19;
    localparam logic [4:0] KIND_ARROW      = 5'd20;
    localparam logic [4:0] KIND_LE         = 5'd21;
    localparam logic [4:0] KIND_LT         = 5'd22;
    localparam logic [4:0] KIND_GE         = 5'd23;
    localparam logic [4:0] KIND_GT         = 5'd24;
    localparam logic [4:0] KIND_AND        = 5'd25;
    localparam logic [4:0] KIND_OR         = 5'd26;
    localparam logic [4:0] KIND_COMMA      = 5'd27;
    localparam logic [4:0] KIND_SEMICOLON  = 5'd28;
    localparam logic [4:0] KIND_COLON      = 5'd29;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_EXTRA_POINT = 3'd1;
    localparam logic [2:0] ERR_BAD_EOL     = 3'd2;
    localparam logic [2:0] ERR_LONE_AMP    = 3'd3;
    localparam logic [2:0] ERR_LONE_BAR    = 3'd4;
    localparam logic [2:0] ERR_UNEXPECTED  = 3'd5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    function automatic char_t classify(input logic [7:0] b);
        char_t r;
        r.code  = b;
        r.digit = (b >= 8'h30) && (b <= 8'h39);
        r.alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
        return r;
    endfunction

endpackage

@@ rtl/dct_front.sv @@
// ----------------------------------------------------------------------------
// dct_front
// accepts text bytes, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module dct_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    output dct_pkg::head_t  head,
    input  logic            take
);

    dct_pkg::char_t mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign in_ready   = (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign pop        = take && (cnt_reg != 2'd0);
    assign head.valid = (cnt_reg != 2'd0);
    assign head.ch    = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= dct_pkg::classify(in_byte);
        end
    end

endmodule

@@ rtl/dct_back.sv @@
// ----------------------------------------------------------------------------
// dct_back
// scanner engine: one scan step per cycle while the token queue has room, over up to three buffered bytes
// ----------------------------------------------------------------------------
module dct_back
#(
    parameter int POSITION_WIDTH = dct_pkg::POSITION_WIDTH_DEF,
    parameter int LENGTH_WIDTH   = dct_pkg::LENGTH_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dct_pkg::head_t         head,
    output logic                   take,
    input  logic                   room,
    output dct_pkg::push_t         push,
    output logic [dct_pkg::KIND_W+dct_pkg::ERR_W+2*POSITION_WIDTH+LENGTH_WIDTH:0] word_a,
    output logic [dct_pkg::KIND_W+dct_pkg::ERR_W+2*POSITION_WIDTH+LENGTH_WIDTH:0] word_b
);

    localparam int P    = POSITION_WIDTH;
    localparam int L    = LENGTH_WIDTH;
    localparam int TK_W = dct_pkg::KIND_W + dct_pkg::ERR_W + 2 * P + L;

    localparam dct_pkg::char_t ZERO_CH = '{code: 8'h00, digit: 1'b0, alpha: 1'b0};

    dct_pkg::char_t q_reg [3];
    dct_pkg::char_t q_next [3];
    logic [1:0]     mode_reg, mode_next;
    logic [1:0]     qn_reg, qn_next;
    logic           end_reg, end_next;
    logic [P-1:0]   line_reg, line_next;
    logic [P-1:0]   col_reg, col_next;
    logic [P-1:0]   sl_reg, sl_next;
    logic [P-1:0]   sc_reg, sc_next;
    logic [L-1:0]   len_reg, len_next;
    logic           point_reg, point_next;
    logic           exp_reg, exp_next;
    logic           busy_reg, busy_next;
    logic           pend_v_reg, pend_v_next;
    logic [TK_W-1:0] pend_reg, pend_next;

    dct_pkg::char_t e_q [3];
    logic [1:0]     e_qn;
    logic           e_end;
    logic           run;
    logic           k0, k1, k2;
    dct_pkg::char_t v0, v1, v2;
    logic [7:0]     c;
    logic           ret;
    logic           clear;
    logic [1:0]     npop;
    logic [1:0]     grow;
    logic           nl;
    logic           mark;
    logic           cr_mark;
    logic [P-1:0]   mcol;
    logic           tok_v;
    logic [4:0]     tok_kind;
    logic [2:0]     tok_err;
    logic           tok_fixed;
    logic [1:0]     tok_flen;
    logic [L-1:0]   tok_len;
    logic [TK_W-1:0] tok;
    logic           nk0, nk1, nk2;
    dct_pkg::char_t nv0, nv1;
    logic           nstop;
    logic           step_end;

    function automatic logic [P-1:0] psat(input logic [P-1:0] v, input logic [1:0] k);
        logic [P:0] s;
        s = {1'b0, v} + {{(P-1){1'b0}}, k};
        return s[P] ? {P{1'b1}} : s[P-1:0];
    endfunction

    function automatic logic [L-1:0] lsat(input logic [L-1:0] v, input logic [1:0] k);
        logic [L:0] s;
        s = {1'b0, v} + {{(L-1){1'b0}}, k};
        return s[L] ? {L{1'b1}} : s[L-1:0];
    endfunction

    assign run  = (busy_reg || head.valid) && room;
    assign take = run && !busy_reg;

    // effective buffer: a new byte joins when no step is open
    always_comb
    begin
        e_q   = q_reg;
        e_qn  = qn_reg;
        e_end = end_reg;
        if (!busy_reg)
        begin
            e_end = (head.ch.code == dct_pkg::CH_NUL);
            if (!e_end)
            begin
                e_q[qn_reg] = head.ch;
                e_qn        = qn_reg + 2'd1;
            end
        end
        k0 = (e_qn > 2'd0) || e_end;
        k1 = (e_qn > 2'd1) || e_end;
        k2 = (e_qn > 2'd2) || e_end;
        v0 = (e_qn > 2'd0) ? e_q[0] : ZERO_CH;
        v1 = (e_qn > 2'd1) ? e_q[1] : ZERO_CH;
        v2 = (e_qn > 2'd2) ? e_q[2] : ZERO_CH;
        c  = v0.code;
    end

    // one scan step
    always_comb
    begin
        ret        = 1'b0;
        clear      = 1'b0;
        npop       = 2'd0;
        grow       = 2'd0;
        nl         = 1'b0;
        mark       = 1'b0;
        cr_mark    = 1'b0;
        tok_v      = 1'b0;
        tok_kind   = dct_pkg::KIND_EOF;
        tok_err    = dct_pkg::ERR_NONE;
        tok_fixed  = 1'b0;
        tok_flen   = 2'd0;
        mode_next  = mode_reg;
        point_next = point_reg;
        exp_next   = exp_reg;
        if (!k0)
        begin
            ret = 1'b1;
        end
        else
        begin
            case (mode_reg)
                dct_pkg::MODE_COMMENT:
                begin
                    if (c == dct_pkg::CH_LF || c == dct_pkg::CH_NUL)
                        mode_next = dct_pkg::MODE_IDLE;
                    else
                        npop = 2'd1;
                end
                dct_pkg::MODE_IDENT:
                begin
                    if (v0.alpha || v0.digit || c == dct_pkg::CH_UNDER || c == dct_pkg::CH_QUOTE)
                    begin
                        npop = 2'd1;
                        grow = 2'd1;
                    end
                    else
                    begin
                        tok_v     = 1'b1;
                        tok_kind  = dct_pkg::KIND_IDENTIFIER;
                        mode_next = dct_pkg::MODE_IDLE;
                    end
                end
                dct_pkg::MODE_NUMBER:
                begin
                    if (v0.digit)
                    begin
                        npop = 2'd1;
                        grow = 2'd1;
                    end
                    else if (c == dct_pkg::CH_DOT)
                    begin
                        if (point_reg)
                        begin
                            tok_v     = 1'b1;
                            tok_kind  = dct_pkg::KIND_ERROR;
                            tok_err   = dct_pkg::ERR_EXTRA_POINT;
                            mode_next = dct_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            point_next = 1'b1;
                            npop       = 2'd1;
                            grow       = 2'd1;
                            if (exp_reg)
                            begin
                                tok_v     = 1'b1;
                                tok_kind  = dct_pkg::KIND_ERROR;
                                tok_err   = dct_pkg::ERR_EXTRA_POINT;
                                mode_next = dct_pkg::MODE_IDLE;
                            end
                        end
                    end
                    else if (!exp_reg && (c == dct_pkg::CH_LOWER_E || c == dct_pkg::CH_UPPER_E))
                    begin
                        if (!k1)
                            ret = 1'b1;
                        else if (v1.digit)
                        begin
                            exp_next = 1'b1;
                            npop     = 2'd1;
                            grow     = 2'd1;
                        end
                        else if (v1.code != dct_pkg::CH_PLUS && v1.code != dct_pkg::CH_MINUS)
                        begin
                            tok_v     = 1'b1;
                            tok_kind  = (exp_reg || point_reg) ? dct_pkg::KIND_FLOAT
                                                               : dct_pkg::KIND_INTEGER;
                            mode_next = dct_pkg::MODE_IDLE;
                        end
                        else if (!k2)
                            ret = 1'b1;
                        else if (v2.digit)
                        begin
                            exp_next = 1'b1;
                            npop     = 2'd2;
                            grow     = 2'd2;
                        end
                        else
                        begin
                            tok_v     = 1'b1;
                            tok_kind  = (exp_reg || point_reg) ? dct_pkg::KIND_FLOAT
                                                               : dct_pkg::KIND_INTEGER;
                            mode_next = dct_pkg::MODE_IDLE;
                        end
                    end
                    else
                    begin
                        tok_v     = 1'b1;
                        tok_kind  = (exp_reg || point_reg) ? dct_pkg::KIND_FLOAT
                                                           : dct_pkg::KIND_INTEGER;
                        mode_next = dct_pkg::MODE_IDLE;
                    end
                end
                default:
                begin
                    case (c)
                        dct_pkg::CH_NUL:
                        begin
                            mark      = 1'b1;
                            tok_v     = 1'b1;
                            tok_kind  = dct_pkg::KIND_EOF;
                            tok_fixed = 1'b1;
                            clear     = 1'b1;
                        end
                        dct_pkg::CH_SPACE, dct_pkg::CH_TAB, dct_pkg::CH_VT, dct_pkg::CH_FF:
                        begin
                            npop = 2'd1;
                        end
                        dct_pkg::CH_LF:
                        begin
                            npop = 2'd1;
                            nl   = 1'b1;
                        end
                        dct_pkg::CH_CR:
                        begin
                            if (!k1)
                                ret = 1'b1;
                            else
                            begin
                                npop = 2'd1;
                                if (v1.code != dct_pkg::CH_LF)
                                begin
                                    mark      = 1'b1;
                                    cr_mark   = 1'b1;
                                    tok_v     = 1'b1;
                                    tok_kind  = dct_pkg::KIND_ERROR;
                                    tok_err   = dct_pkg::ERR_BAD_EOL;
                                    tok_fixed = 1'b1;
                                end
                            end
                        end
                        dct_pkg::CH_HASH:
                        begin
                            mode_next = dct_pkg::MODE_COMMENT;
                        end
                        dct_pkg::CH_LPAREN, dct_pkg::CH_RPAREN, dct_pkg::CH_LBRACE,
                        dct_pkg::CH_RBRACE, dct_pkg::CH_PLUS, dct_pkg::CH_SLASH,
                        dct_pkg::CH_STAR, dct_pkg::CH_CARET, dct_pkg::CH_COMMA,
                        dct_pkg::CH_SEMI, dct_pkg::CH_COLON:
                        begin
                            mark      = 1'b1;
                            tok_v     = 1'b1;
                            tok_fixed = 1'b1;
                            tok_flen  = 2'd1;
                            npop      = 2'd1;
                            case (c)
                                dct_pkg::CH_LPAREN: tok_kind = dct_pkg::KIND_LPAREN;
                                dct_pkg::CH_RPAREN: tok_kind = dct_pkg::KIND_RPAREN;
                                dct_pkg::CH_LBRACE: tok_kind = dct_pkg::KIND_LBRACE;
                                dct_pkg::CH_RBRACE: tok_kind = dct_pkg::KIND_RBRACE;
                                dct_pkg::CH_PLUS:   tok_kind = dct_pkg::KIND_PLUS;
                                dct_pkg::CH_SLASH:  tok_kind = dct_pkg::KIND_DIVIDE;
                                dct_pkg::CH_STAR:   tok_kind = dct_pkg::KIND_TIMES;
                                dct_pkg::CH_CARET:  tok_kind = dct_pkg::KIND_POWER;
                                dct_pkg::CH_COMMA:  tok_kind = dct_pkg::KIND_COMMA;
                                dct_pkg::CH_SEMI:   tok_kind = dct_pkg::KIND_SEMICOLON;
                                default:            tok_kind = dct_pkg::KIND_COLON;
                            endcase
                        end
                        dct_pkg::CH_DOT:
                        begin
                            if (!k1)
                                ret = 1'b1;
                            else if (v1.digit)
                            begin
                                mark       = 1'b1;
                                mode_next  = dct_pkg::MODE_NUMBER;
                                point_next = 1'b1;
                                exp_next   = 1'b0;
                                npop       = 2'd1;
                                grow       = 2'd1;
                            end
                            else
                            begin
                                mark      = 1'b1;
                                tok_v     = 1'b1;
                                tok_kind  = dct_pkg::KIND_DOT;
                                tok_fixed = 1'b1;
                                tok_flen  = 2'd1;
                                npop      = 2'd1;
                            end
                        end
                        dct_pkg::CH_EQ, dct_pkg::CH_BANG, dct_pkg::CH_MINUS,
                        dct_pkg::CH_GT, dct_pkg::CH_AMP, dct_pkg::CH_BAR:
                        begin
                            if (!k1)
                                ret = 1'b1;
                            else
                            begin
                                mark      = 1'b1;
                                tok_v     = 1'b1;
                                tok_fixed = 1'b1;
                                tok_flen  = 2'd1;
                                npop      = 2'd1;
                                case (c)
                                    dct_pkg::CH_EQ:
                                    begin
                                        tok_kind = dct_pkg::KIND_ASSIGN;
                                        if (v1.code == dct_pkg::CH_EQ)
                                        begin
                                            tok_kind = dct_pkg::KIND_EQUALITY;
                                            tok_flen = 2'd2;
                                            npop     = 2'd2;
                                        end
                                    end
                                    dct_pkg::CH_BANG:
                                    begin
                                        tok_kind = dct_pkg::KIND_NOT;
                                        if (v1.code == dct_pkg::CH_EQ)
                                        begin
                                            tok_kind = dct_pkg::KIND_NOTEQUAL;
                                            tok_flen = 2'd2;
                                            npop     = 2'd2;
                                        end
                                    end
                                    dct_pkg::CH_MINUS:
                                    begin
                                        tok_kind = dct_pkg::KIND_MINUS;
                                        if (v1.code == dct_pkg::CH_GT)
                                        begin
                                            tok_kind = dct_pkg::KIND_RETURNS;
                                            tok_flen = 2'd2;
                                            npop     = 2'd2;
                                        end
                                    end
                                    dct_pkg::CH_GT:
                                    begin
                                        tok_kind = dct_pkg::KIND_GT;
                                        if (v1.code == dct_pkg::CH_EQ)
                                        begin
                                            tok_kind = dct_pkg::KIND_GE;
                                            tok_flen = 2'd2;
                                            npop     = 2'd2;
                                        end
                                    end
                                    dct_pkg::CH_AMP:
                                    begin
                                        tok_kind = dct_pkg::KIND_ERROR;
                                        tok_err  = dct_pkg::ERR_LONE_AMP;
                                        if (v1.code == dct_pkg::CH_AMP)
                                        begin
                                            tok_kind = dct_pkg::KIND_AND;
                                            tok_err  = dct_pkg::ERR_NONE;
                                            tok_flen = 2'd2;
                                            npop     = 2'd2;
                                        end
                                    end
                                    default:
                                    begin
                                        tok_kind = dct_pkg::KIND_ERROR;
                                        tok_err  = dct_pkg::ERR_LONE_BAR;
                                        if (v1.code == dct_pkg::CH_BAR)
                                        begin
                                            tok_kind = dct_pkg::KIND_OR;
                                            tok_err  = dct_pkg::ERR_NONE;
                                            tok_flen = 2'd2;
                                            npop     = 2'd2;
                                        end
                                    end
                                endcase
                            end
                        end
                        dct_pkg::CH_LT:
                        begin
                            if (!k1)
                                ret = 1'b1;
                            else if (v1.code == dct_pkg::CH_MINUS && !k2)
                                ret = 1'b1;
                            else
                            begin
                                mark      = 1'b1;
                                tok_v     = 1'b1;
                                tok_fixed = 1'b1;
                                if (v1.code == dct_pkg::CH_MINUS && v2.code == dct_pkg::CH_GT)
                                begin
                                    tok_kind = dct_pkg::KIND_ARROW;
                                    tok_flen = 2'd3;
                                    npop     = 2'd3;
                                end
                                else if (v1.code == dct_pkg::CH_EQ)
                                begin
                                    tok_kind = dct_pkg::KIND_LE;
                                    tok_flen = 2'd2;
                                    npop     = 2'd2;
                                end
                                else
                                begin
                                    tok_kind = dct_pkg::KIND_LT;
                                    tok_flen = 2'd1;
                                    npop     = 2'd1;
                                end
                            end
                        end
                        default:
                        begin
                            mark = 1'b1;
                            npop = 2'd1;
                            if (v0.digit)
                            begin
                                mode_next  = dct_pkg::MODE_NUMBER;
                                point_next = 1'b0;
                                exp_next   = 1'b0;
                                grow       = 2'd1;
                            end
                            else if (v0.alpha)
                            begin
                                mode_next = dct_pkg::MODE_IDENT;
                                grow      = 2'd1;
                            end
                            else
                            begin
                                tok_v     = 1'b1;
                                tok_kind  = dct_pkg::KIND_ERROR;
                                tok_err   = dct_pkg::ERR_UNEXPECTED;
                                tok_fixed = 1'b1;
                                tok_flen  = 2'd1;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    // apply pops, marks and growth
    always_comb
    begin
        case (npop)
            2'd0:
            begin
                q_next[0] = e_q[0];
                q_next[1] = e_q[1];
                q_next[2] = e_q[2];
            end
            2'd1:
            begin
                q_next[0] = e_q[1];
                q_next[1] = e_q[2];
                q_next[2] = ZERO_CH;
            end
            2'd2:
            begin
                q_next[0] = e_q[2];
                q_next[1] = ZERO_CH;
                q_next[2] = ZERO_CH;
            end
            default:
            begin
                q_next[0] = ZERO_CH;
                q_next[1] = ZERO_CH;
                q_next[2] = ZERO_CH;
            end
        endcase
        qn_next   = e_qn - npop;
        end_next  = e_end;
        line_next = nl ? psat(line_reg, 2'd1) : line_reg;
        col_next  = nl ? {P{1'b0}} : psat(col_reg, npop);
        mcol      = cr_mark ? psat(col_reg, 2'd1) : col_reg;
        sl_next   = mark ? psat(line_reg, 2'd1) : sl_reg;
        sc_next   = mark ? psat(mcol, 2'd1) : sc_reg;
        len_next  = lsat(mark ? {L{1'b0}} : len_reg, grow);
        tok_len   = tok_fixed ? {{(L-2){1'b0}}, tok_flen} : len_next;
        tok       = {tok_len, sc_next, sl_next, tok_err, tok_kind};
        if (ret)
        begin
            q_next    = e_q;
            qn_next   = e_qn;
            line_next = line_reg;
            col_next  = col_reg;
            sl_next   = sl_reg;
            sc_next   = sc_reg;
            len_next  = len_reg;
        end
        if (clear)
        begin
            q_next[0] = ZERO_CH;
            q_next[1] = ZERO_CH;
            q_next[2] = ZERO_CH;
            qn_next   = 2'd0;
            line_next = {P{1'b0}};
            col_next  = {P{1'b0}};
            sl_next   = {P{1'b0}};
            sc_next   = {P{1'b0}};
            len_next  = {L{1'b0}};
        end
    end

    // does the state left behind need another byte
    always_comb
    begin
        nk0   = (qn_next > 2'd0) || end_next;
        nk1   = (qn_next > 2'd1) || end_next;
        nk2   = (qn_next > 2'd2) || end_next;
        nv0   = (qn_next > 2'd0) ? q_next[0] : ZERO_CH;
        nv1   = (qn_next > 2'd1) ? q_next[1] : ZERO_CH;
        nstop = 1'b0;
        if (!nk0)
            nstop = 1'b1;
        else if (mode_next == dct_pkg::MODE_NUMBER)
        begin
            if (!exp_next && (nv0.code == dct_pkg::CH_LOWER_E ||
                              nv0.code == dct_pkg::CH_UPPER_E))
            begin
                if (!nk1)
                    nstop = 1'b1;
                else if (!nv1.digit && (nv1.code == dct_pkg::CH_PLUS ||
                                        nv1.code == dct_pkg::CH_MINUS) && !nk2)
                    nstop = 1'b1;
            end
        end
        else if (mode_next == dct_pkg::MODE_IDLE)
        begin
            if ((nv0.code == dct_pkg::CH_CR || nv0.code == dct_pkg::CH_DOT ||
                 nv0.code == dct_pkg::CH_EQ || nv0.code == dct_pkg::CH_BANG ||
                 nv0.code == dct_pkg::CH_MINUS || nv0.code == dct_pkg::CH_GT ||
                 nv0.code == dct_pkg::CH_AMP || nv0.code == dct_pkg::CH_BAR ||
                 nv0.code == dct_pkg::CH_LT) && !nk1)
                nstop = 1'b1;
            else if (nv0.code == dct_pkg::CH_LT && nv1.code == dct_pkg::CH_MINUS && !nk2)
                nstop = 1'b1;
        end
    end

    // hold back the latest token until the step ends so it can carry the last mark
    always_comb
    begin
        step_end    = ret || clear || nstop;
        busy_next   = !step_end;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        push.a_v    = 1'b0;
        push.b_v    = 1'b0;
        word_a      = {1'b0, pend_reg};
        word_b      = {1'b1, tok};
        if (tok_v)
        begin
            if (step_end)
            begin
                pend_v_next = 1'b0;
                push.a_v    = 1'b1;
                if (pend_v_reg)
                    push.b_v = 1'b1;
                else
                    word_a = {1'b1, tok};
            end
            else
            begin
                push.a_v    = pend_v_reg;
                pend_v_next = 1'b1;
                pend_next   = tok;
            end
        end
        else if (step_end && pend_v_reg)
        begin
            push.a_v    = 1'b1;
            word_a      = {1'b1, pend_reg};
            pend_v_next = 1'b0;
        end
        if (!run)
        begin
            push.a_v    = 1'b0;
            push.b_v    = 1'b0;
            pend_v_next = pend_v_reg;
            pend_next   = pend_reg;
            busy_next   = busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= dct_pkg::MODE_IDLE;
            qn_reg     <= 2'd0;
            end_reg    <= 1'b0;
            line_reg   <= {P{1'b0}};
            col_reg    <= {P{1'b0}};
            sl_reg     <= {P{1'b0}};
            sc_reg     <= {P{1'b0}};
            len_reg    <= {L{1'b0}};
            point_reg  <= 1'b0;
            exp_reg    <= 1'b0;
            busy_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            pend_v_reg <= pend_v_next;
            if (run)
            begin
                mode_reg  <= clear ? dct_pkg::MODE_IDLE : mode_next;
                qn_reg    <= qn_next;
                end_reg   <= end_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
                sl_reg    <= sl_next;
                sc_reg    <= sc_next;
                len_reg   <= len_next;
                point_reg <= clear ? 1'b0 : point_next;
                exp_reg   <= clear ? 1'b0 : exp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (run)
        begin
            q_reg <= q_next;
        end
    end

endmodule

@@ rtl/dct_outq.sv @@
// ----------------------------------------------------------------------------
// dct_outq
// four-entry token queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module dct_outq
#(
    parameter int WORD_W = 57
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dct_pkg::push_t    push,
    input  logic [WORD_W-1:0] word_a,
    input  logic [WORD_W-1:0] word_b,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_word
);

    logic [WORD_W-1:0] mem_reg [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign room      = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_word  = mem_reg[rp_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wp_next  = wp_reg + {1'b0, push.a_v} + {1'b0, push.b_v};
        rp_next  = rp_reg + {1'b0, pop};
        cnt_next = cnt_reg + {2'b0, push.a_v} + {2'b0, push.b_v} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.a_v)
        begin
            mem_reg[wp_reg] <= word_a;
        end
        if (push.b_v)
        begin
            mem_reg[wp_reg + 2'd1] <= word_b;
        end
    end

endmodule

@@ rtl/dsl_character_tokenizer.sv @@
// ----------------------------------------------------------------------------
// dsl_character_tokenizer
// streaming tokenizer: text bytes in, tokens with position and length out
//
//   channel  | dir | payload
//   s_axis   | in  | tdata[7:0] text_byte (0 ends the text)
//   m_axis   | out | tdata: kind, error code, start line, start column, length;
//            |     | tlast: final token caused by one request
//
// one scan step per cycle except while the engine stalls
// a new byte is taken only once the steps for each token closed, or mode change before it, are done
// the engine stalls while the token queue has fewer than two free entries
// a two-entry byte queue and a four-entry token queue let each side stall on its own
// rst_n clears all scan state; after an eof token the state returns to reset
// ----------------------------------------------------------------------------
module dsl_character_tokenizer
#(
    parameter int POSITION_WIDTH = dct_pkg::POSITION_WIDTH_DEF,
    parameter int LENGTH_WIDTH   = dct_pkg::LENGTH_WIDTH_DEF,
    localparam int TK_W    = dct_pkg::KIND_W + dct_pkg::ERR_W + 2 * POSITION_WIDTH + LENGTH_WIDTH,
    localparam int TDATA_W = ((TK_W + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // text_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // token_kind, error_code, start_line,
                                               // start_column, token_length
    output logic               m_axis_tlast
);

    dct_pkg::head_t head;
    dct_pkg::push_t push;
    logic           take;
    logic           room;
    logic [TK_W:0]  word_a;
    logic [TK_W:0]  word_b;
    logic [TK_W:0]  out_word;

    dct_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .head     (head),
        .take     (take)
    );

    dct_back
    #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .LENGTH_WIDTH   (LENGTH_WIDTH)
    )
    u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .take   (take),
        .room   (room),
        .push   (push),
        .word_a (word_a),
        .word_b (word_b)
    );

    dct_outq
    #(
        .WORD_W (TK_W + 1)
    )
    u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .word_a    (word_a),
        .word_b    (word_b),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tlast = out_word[TK_W];
    assign m_axis_tdata = {{(TDATA_W - TK_W){1'b0}}, out_word[TK_W-1:0]};

endmodule

@@ rtl/dct_checker.sv @@
// ----------------------------------------------------------------------------
// dct_checker
// port-level checks on the token stream of the tokenizer
// ----------------------------------------------------------------------------
module dct_checker
#(
    parameter int POSITION_WIDTH = dct_pkg::POSITION_WIDTH_DEF,
    parameter int LENGTH_WIDTH   = dct_pkg::LENGTH_WIDTH_DEF,
    parameter int TDATA_W        = 56
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    localparam int LEN_LSB = dct_pkg::KIND_W + dct_pkg::ERR_W + 2 * POSITION_WIDTH;

    logic [4:0]              kind;
    logic [2:0]              err;
    logic [LENGTH_WIDTH-1:0] len;

    assign kind = m_axis_tdata[4:0];
    assign err  = m_axis_tdata[7:5];
    assign len  = m_axis_tdata[LEN_LSB +: LENGTH_WIDTH];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("token changed while stalled");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (kind == dct_pkg::KIND_ERROR) || (err == dct_pkg::ERR_NONE))
        else $error("error code on a non-error token");

    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && kind == dct_pkg::KIND_EOF |-> m_axis_tlast && len == '0)
        else $error("eof token malformed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> kind <= dct_pkg::KIND_COLON)
        else $error("token kind out of range");

endmodule

bind dsl_character_tokenizer dct_checker
#(
    .POSITION_WIDTH (POSITION_WIDTH),
    .LENGTH_WIDTH   (LENGTH_WIDTH),
    .TDATA_W        (TDATA_W)
)
u_dct_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// tokenizer bench: streams text bytes through directed and random text, checks
// each token against a behavioral scanner kept in the bench, under random
// idling on both streams and long holds on the token side
// ----------------------------------------------------------------------------
module testbench;

    localparam int PW      = 16;
    localparam int LW      = 16;
    localparam int TDATA_W = 56;
    localparam int LIMIT   = 400000;

    localparam logic [1:0] SCAN_IDLE    = 2'd0;
    localparam logic [1:0] SCAN_NUMBER  = 2'd1;
    localparam logic [1:0] SCAN_IDENT   = 2'd2;
    localparam logic [1:0] SCAN_COMMENT = 2'd3;

    typedef struct packed {
        logic [4:0]    kind;
        logic [2:0]    err;
        logic [PW-1:0] line;
        logic [PW-1:0] col;
        logic [LW-1:0] len;
        logic          last;
    } token_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'd0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;

    dsl_character_tokenizer DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #1 clk = ~clk;

    // scanner state
    logic [1:0]    mode;
    logic [7:0]    ahead [2];
    int            ahead_n;
    logic [PW-1:0] cur_line, cur_col, tok_line, tok_col;
    logic [LW-1:0] tok_len;
    bit            point_seen, expo_seen;
    logic [7:0]    q [3];
    int            qn;
    bit            at_end;
    token_t        pending_tokens [$];
    token_t        step_tokens [$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  quiet_tx = 0, quiet_rx = 0, hold_rx = 0;

    function automatic logic [PW-1:0] pinc(logic [PW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic bit is_dig(int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alp(int c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic scan_reset();
        mode = SCAN_IDLE; ahead[0] = 0; ahead[1] = 0; ahead_n = 0;
        cur_line = 0; cur_col = 0; tok_line = 0; tok_col = 0; tok_len = 0;
        point_seen = 0; expo_seen = 0;
    endtask

    function automatic int peek(int i);
        if (i < qn) return q[i];
        return at_end ? 0 : -1;
    endfunction

    task automatic pop();
        if (qn == 0) return;
        q[0] = q[1]; q[1] = q[2]; qn--;
        cur_col = pinc(cur_col);
    endtask

    task automatic grow();
        pop();
        tok_len = (tok_len == '1) ? tok_len : tok_len + 1'b1;
    endtask

    task automatic mark();
        tok_line = pinc(cur_line); tok_col = pinc(cur_col); tok_len = 0;
    endtask

    task automatic put(logic [4:0] k, logic [2:0] e, logic [LW-1:0] n);
        token_t t;
        t.kind = k; t.err = e; t.line = tok_line; t.col = tok_col; t.len = n; t.last = 0;
        if (step_tokens.size() < 4) step_tokens.push_back(t);
    endtask

    task automatic put_here(logic [4:0] k, logic [2:0] e, int n);
        mark();
        put(k, e, LW'(n));
        repeat (n) pop();
    endtask

    task automatic put_number();
        put((expo_seen || point_seen) ? dct_pkg::KIND_FLOAT : dct_pkg::KIND_INTEGER,
            dct_pkg::ERR_NONE, tok_len);
        mode = SCAN_IDLE;
    endtask

    // advances the scan as far as the known bytes allow
    task automatic scan_run();
        int c, c0, c1;
        forever begin
            c = peek(0);
            if (c < 0) return;
            if (mode == SCAN_COMMENT) begin
                if (c == dct_pkg::CH_LF || c == 0) mode = SCAN_IDLE; else pop();
                continue;
            end
            if (mode == SCAN_IDENT) begin
                if (is_alp(c) || is_dig(c) || c == dct_pkg::CH_UNDER || c == dct_pkg::CH_QUOTE)
                    grow();
                else begin
                    put(dct_pkg::KIND_IDENTIFIER, dct_pkg::ERR_NONE, tok_len);
                    mode = SCAN_IDLE;
                end
                continue;
            end
            if (mode == SCAN_NUMBER) begin
                if (is_dig(c)) begin grow(); continue; end
                if (c == dct_pkg::CH_DOT) begin
                    if (point_seen) begin
                        put(dct_pkg::KIND_ERROR, dct_pkg::ERR_EXTRA_POINT, tok_len);
                        mode = SCAN_IDLE;
                        continue;
                    end
                    point_seen = 1; grow();
                    if (expo_seen) begin
                        put(dct_pkg::KIND_ERROR, dct_pkg::ERR_EXTRA_POINT, tok_len);
                        mode = SCAN_IDLE;
                    end
                    continue;
                end
                if (!expo_seen && (c == dct_pkg::CH_LOWER_E || c == dct_pkg::CH_UPPER_E)) begin
                    c0 = peek(1);
                    if (c0 < 0) return;
                    if (!is_dig(c0)) begin
                        if (c0 != dct_pkg::CH_PLUS && c0 != dct_pkg::CH_MINUS) begin
                            put_number();
                            continue;
                        end
                        c1 = peek(2);
                        if (c1 < 0) return;
                        if (!is_dig(c1)) begin put_number(); continue; end
                    end
                    expo_seen = 1; grow();
                    if (c0 == dct_pkg::CH_PLUS || c0 == dct_pkg::CH_MINUS) grow();
                    continue;
                end
                put_number();
                continue;
            end
            c0 = peek(1);
            case (c)
                dct_pkg::CH_NUL: begin
                    mark(); put(dct_pkg::KIND_EOF, dct_pkg::ERR_NONE, '0);
                    scan_reset(); qn = 0; return;
                end
                dct_pkg::CH_SPACE, dct_pkg::CH_TAB, dct_pkg::CH_VT, dct_pkg::CH_FF: pop();
                dct_pkg::CH_LF: begin
                    cur_line = pinc(cur_line);
                    q[0] = q[1]; q[1] = q[2]; qn--;
                    cur_col = 0;
                end
                dct_pkg::CH_CR: begin
                    if (c0 < 0) return;
                    pop();
                    if (c0 != dct_pkg::CH_LF)
                        put_here(dct_pkg::KIND_ERROR, dct_pkg::ERR_BAD_EOL, 0);
                end
                dct_pkg::CH_HASH:   mode = SCAN_COMMENT;
                dct_pkg::CH_LPAREN: put_here(dct_pkg::KIND_LPAREN, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_RPAREN: put_here(dct_pkg::KIND_RPAREN, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_LBRACE: put_here(dct_pkg::KIND_LBRACE, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_RBRACE: put_here(dct_pkg::KIND_RBRACE, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_PLUS:   put_here(dct_pkg::KIND_PLUS, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_SLASH:  put_here(dct_pkg::KIND_DIVIDE, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_STAR:   put_here(dct_pkg::KIND_TIMES, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_CARET:  put_here(dct_pkg::KIND_POWER, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_COMMA:  put_here(dct_pkg::KIND_COMMA, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_SEMI:   put_here(dct_pkg::KIND_SEMICOLON, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_COLON:  put_here(dct_pkg::KIND_COLON, dct_pkg::ERR_NONE, 1);
                dct_pkg::CH_DOT: begin
                    if (c0 < 0) return;
                    if (is_dig(c0)) begin
                        mark(); mode = SCAN_NUMBER; point_seen = 1; expo_seen = 0; grow();
                    end else put_here(dct_pkg::KIND_DOT, dct_pkg::ERR_NONE, 1);
                end
                dct_pkg::CH_EQ: begin
                    if (c0 < 0) return;
                    if (c0 == dct_pkg::CH_EQ)
                        put_here(dct_pkg::KIND_EQUALITY, dct_pkg::ERR_NONE, 2);
                    else put_here(dct_pkg::KIND_ASSIGN, dct_pkg::ERR_NONE, 1);
                end
                dct_pkg::CH_BANG: begin
                    if (c0 < 0) return;
                    if (c0 == dct_pkg::CH_EQ)
                        put_here(dct_pkg::KIND_NOTEQUAL, dct_pkg::ERR_NONE, 2);
                    else put_here(dct_pkg::KIND_NOT, dct_pkg::ERR_NONE, 1);
                end
                dct_pkg::CH_MINUS: begin
                    if (c0 < 0) return;
                    if (c0 == dct_pkg::CH_GT)
                        put_here(dct_pkg::KIND_RETURNS, dct_pkg::ERR_NONE, 2);
                    else put_here(dct_pkg::KIND_MINUS, dct_pkg::ERR_NONE, 1);
                end
                dct_pkg::CH_GT: begin
                    if (c0 < 0) return;
                    if (c0 == dct_pkg::CH_EQ) put_here(dct_pkg::KIND_GE, dct_pkg::ERR_NONE, 2);
                    else put_here(dct_pkg::KIND_GT, dct_pkg::ERR_NONE, 1);
                end
                dct_pkg::CH_AMP: begin
                    if (c0 < 0) return;
                    if (c0 == dct_pkg::CH_AMP)
                        put_here(dct_pkg::KIND_AND, dct_pkg::ERR_NONE, 2);
                    else put_here(dct_pkg::KIND_ERROR, dct_pkg::ERR_LONE_AMP, 1);
                end
                dct_pkg::CH_BAR: begin
                    if (c0 < 0) return;
                    if (c0 == dct_pkg::CH_BAR)
                        put_here(dct_pkg::KIND_OR, dct_pkg::ERR_NONE, 2);
                    else put_here(dct_pkg::KIND_ERROR, dct_pkg::ERR_LONE_BAR, 1);
                end
                dct_pkg::CH_LT: begin
                    if (c0 < 0) return;
                    if (c0 == dct_pkg::CH_MINUS) begin
                        c1 = peek(2);
                        if (c1 < 0) return;
                        if (c1 == dct_pkg::CH_GT) begin
                            put_here(dct_pkg::KIND_ARROW, dct_pkg::ERR_NONE, 3);
                            continue;
                        end
                    end
                    if (c0 == dct_pkg::CH_EQ) put_here(dct_pkg::KIND_LE, dct_pkg::ERR_NONE, 2);
                    else put_here(dct_pkg::KIND_LT, dct_pkg::ERR_NONE, 1);
                end
                default: begin
                    if (is_dig(c)) begin
                        mark(); mode = SCAN_NUMBER; point_seen = 0; expo_seen = 0; grow();
                    end else if (is_alp(c)) begin
                        mark(); mode = SCAN_IDENT; grow();
                    end else put_here(dct_pkg::KIND_ERROR, dct_pkg::ERR_UNEXPECTED, 1);
                end
            endcase
        end
    endtask

    task automatic predict_byte(logic [7:0] b);
        token_t t;
        qn = ahead_n;
        q[0] = ahead[0]; q[1] = ahead[1]; q[2] = 0;
        at_end = (b == 0);
        if (!at_end) begin q[qn] = b; qn++; end
        step_tokens.delete();
        scan_run();
        if (qn > 2) qn = 2;
        ahead[0] = qn > 0 ? q[0] : 8'd0;
        ahead[1] = qn > 1 ? q[1] : 8'd0;
        ahead_n = qn;
        for (int i = 0; i < step_tokens.size(); i++) begin
            t = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            pending_tokens.push_back(t);
        end
    endtask

    // sends one byte and books the tokens it causes
    task automatic send_byte(logic [7:0] b);
        while (!quiet_tx && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_byte(b);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        token_t want;
        logic [TDATA_W-1:0] got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected token %h", got);
            end else begin
                want = pending_tokens.pop_front();
                if (got[4:0] !== want.kind || got[7:5] !== want.err ||
                    got[23:8] !== want.line || got[39:24] !== want.col ||
                    got[55:40] !== want.len || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("token mismatch: expected k%0d e%0d %0d:%0d len %0d last %0d,",
                                 want.kind, want.err, want.line, want.col, want.len,
                                 want.last, " got k%0d e%0d %0d:%0d len %0d last %0d",
                                 got[4:0], got[7:5], got[23:8], got[39:24], got[55:40],
                                 m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk) begin
        m_axis_tready <= !hold_rx && (quiet_rx || $urandom_range(99) >= 28);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] rand_char();
        int r;
        string pool;
        r = $urandom_range(99);
        pool = "(){}+-*/^,;:.=!<>&|#";
        if (r < 25) return 8'("0" + $urandom_range(9));
        if (r < 45) return 8'("a" + $urandom_range(25));
        if (r < 52) return 8'("A" + $urandom_range(25));
        if (r < 62) return dct_pkg::CH_SPACE;
        if (r < 66) return dct_pkg::CH_LF;
        if (r < 80) return pool[$urandom_range(pool.len() - 1)];
        if (r < 83) return dct_pkg::CH_CR;
        if (r < 86) return dct_pkg::CH_UNDER;
        if (r < 88) return dct_pkg::CH_QUOTE;
        if (r < 92) return 8'(128 + $urandom_range(127));
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic test_operators();
        send_text("(){}+-*/^,;:= == ! != -> - > >= & && | || < <= <-> <-x . a");
        send_byte(dct_pkg::CH_NUL);
    endtask

    task automatic test_numbers_and_names();
        send_text("12 3.5 .5 1.2.3 1e5 2E+7 3e-x 4ex 5e.1 7e2.8 ab_c'9 _ ' ");
        send_byte(dct_pkg::CH_NUL);
    endtask

    task automatic test_line_endings();
        send_text("a\r\nb\rc # note\n\t\v\f x\r");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("12#");
        send_byte(dct_pkg::CH_NUL);
        send_text("4e+");
        send_byte(dct_pkg::CH_NUL);
    endtask

    task automatic test_random_text();
        string frag [6] = '{"x = 1.5e+3;", "f(a, b) -> c", "<->", "1.2.", "a && b || !c",
                            "# c\n"};
        for (int n = 0; n < 76; n++) begin
            if (n == 20) quiet_tx = 1;
            if (n == 50) quiet_tx = 0;
            if (n % 35 == 34) send_byte(dct_pkg::CH_NUL);
            else if ($urandom_range(9) == 0) send_text(frag[$urandom_range(5)]);
            else send_byte(rand_char());
        end
        send_byte(dct_pkg::CH_NUL);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1;
                repeat (150) @(posedge clk);
                hold_rx = 0;
            end
            send_text("(((((((((()))))))))) ,,,,,,");
        join
        send_byte(dct_pkg::CH_NUL);
        drain();
        quiet_rx = 1;
        send_text("a+b*c");
        send_byte(dct_pkg::CH_NUL);
        quiet_rx = 0;
    endtask

    initial begin
        scan_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_operators();
        test_numbers_and_names();
        test_line_endings();
        drain();
        test_backpressure();
        test_random_text();
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_tokens.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
